// ----- src/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, keyword table and helpers for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int KW_MAX_LEN = 20;
  localparam int KW_NUM     = 5;

  localparam logic [7:0]  SEP_RESET = 8'd32;
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [4:0]  POS_MAX   = 5'd31;

  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_ADD_STATION = 3'd1,
    CMD_DEL_STATION = 3'd2,
    CMD_ADD_CAR     = 3'd3,
    CMD_REMOVE_CAR  = 3'd4,
    CMD_PLAN_PATH   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  // string literals sit right-aligned: first character in the top used byte
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_NUM] = '{
    "aggiungi-stazione",
    "demolisci-stazione",
    "aggiungi-auto",
    "rottama-auto",
    "pianifica-percorso"
  };
  localparam logic [4:0] KW_LEN [KW_NUM] = '{5'd17, 5'd18, 5'd13, 5'd12, 5'd18};

  typedef struct packed {
    logic        is_summary;
    logic [30:0] param_value;
    logic [15:0] param_index;
    logic [2:0]  cmd_code;
    logic [15:0] param_count;
    logic        is_valid;
  } res_t;

  // results caused by one input beat, in delivery order p1, p2, sm
  typedef struct packed {
    logic [2:0] mask;
    res_t       p1;
    res_t       p2;
    res_t       sm;
  } grp_t;

  // does keyword k accept character c at position pos
  function automatic logic kw_hit(input int k, input logic [4:0] pos,
                                  input logic [7:0] c);
    logic [4:0] off;
    logic [7:0] ch;
    off = KW_LEN[k] - 5'd1 - pos;
    ch  = KW_TEXT[k][{off, 3'b000} +: 8];
    return (pos < KW_LEN[k]) && (ch == c);
  endfunction

  function automatic logic count_ok(input logic [2:0] code, input logic [15:0] cnt);
    logic ok;
    unique case (code)
      CMD_ADD_STATION: ok = (cnt != 16'd0);
      CMD_DEL_STATION: ok = (cnt == 16'd1);
      CMD_ADD_CAR,
      CMD_REMOVE_CAR,
      CMD_PLAN_PATH:   ok = (cnt == 16'd2);
      default:         ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- src/command_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Command line tokenizer: keyword match, atoi parameters, line summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one character beat per cycle while
//   not stalled, char_code with end_of_line set on the line's last character.
//   Output channel (out_valid / out_stall): result beats, parameter results
//   (is_summary 0) and one summary per line (is_summary 1); last_result
//   marks the final result caused by an input beat.
//   Config channel (cfg_valid / cfg_ready, cfg_data): sets the separator
//   character; always ready; write only while idle.
// A beat's results are registered and appear in the cycle after it is taken.
// Throughput: one character per cycle when a beat causes at most one
//   result and out_stall is low; a beat causing more results stalls the
//   input while the result register hands them out, one per unstalled cycle.
// Reset: separator returns to space, line state clears, no results pending.
// Receiver stall: the result register holds; in_stall stays high while any
//   result is still waiting to go out.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_summary,
  output logic [30:0] param_value,
  output logic [15:0] param_index,
  output logic [2:0]  cmd_code,
  output logic [15:0] param_count,
  output logic        is_valid,
  output logic        last_result
);
  import clt_pkg::*;

  grp_t grp;
  res_t res;
  logic busy;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  clt_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .char_code   (char_code),
    .end_of_line (end_of_line),
    .grp         (grp)
  );

  clt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .grp       (grp),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .last      (last_result)
  );

  assign is_summary   = res.is_summary;
  assign param_value  = res.param_value;
  assign param_index  = res.param_index;
  assign cmd_code     = res.cmd_code;
  assign param_count  = res.param_count;
  assign is_valid     = res.is_valid;

endmodule

// ----- src/clt_parse.sv -----
// ----------------------------------------------------------------------------
// clt_parse
// Line state: keyword matcher, separator counter and atoi-style number
// reader. Updates on each accepted beat and forms that beat's results.
// ----------------------------------------------------------------------------
module clt_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [7:0]      cfg_data,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic            end_of_line,
  output clt_pkg::grp_t   grp
);
  import clt_pkg::*;

  logic [7:0]          separator_char;
  logic [4:0]          keyword_position, keyword_position_next;
  logic [KW_NUM-1:0]   keyword_match_mask, keyword_match_mask_next;
  logic                in_first_token, in_first_token_next;
  logic [2:0]          found_command, found_command_next;
  logic [15:0]         separator_count, separator_count_next;
  logic [30:0]         number_accumulator, number_accumulator_next;
  logic                number_negative, number_negative_next;
  phase_t              number_phase, number_phase_next;

  logic        sep, blank, sign, digit, skip;
  logic [3:0]  dval;
  logic [34:0] prod;
  logic        p1_en, p2_en;
  logic [15:0] sum_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEP_RESET;
    end else if (cfg_valid) begin
      separator_char <= cfg_data;
    end
  end

  always_comb begin
    sep   = (char_code == separator_char);
    blank = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
    sign  = (char_code == 8'd43) || (char_code == 8'd45);
    digit = (char_code >= 8'd48) && (char_code <= 8'd57);
    dval  = 4'(char_code - 8'd48);
    prod  = {4'd0, number_accumulator} * 35'd10 + {31'd0, dval};
    skip  = 1'b0;

    keyword_position_next   = keyword_position;
    keyword_match_mask_next = keyword_match_mask;
    in_first_token_next     = in_first_token;
    found_command_next      = found_command;
    separator_count_next    = separator_count;
    number_accumulator_next = number_accumulator;
    number_negative_next    = number_negative;
    number_phase_next       = number_phase;
    p1_en                   = 1'b0;

    if (sep) begin
      if (in_first_token) begin
        found_command_next = CMD_NONE;
        for (int k = 0; k < KW_NUM; k++) begin
          if (keyword_match_mask[k] && keyword_position == KW_LEN[k])
            found_command_next = 3'(k + 1);
        end
        in_first_token_next = 1'b0;
      end else begin
        p1_en = (found_command != CMD_NONE);
      end
      number_accumulator_next = '0;
      number_negative_next    = 1'b0;
      number_phase_next       = PH_START;
      if (separator_count != COUNT_MAX)
        separator_count_next = separator_count + 16'd1;
    end else if (in_first_token) begin
      for (int k = 0; k < KW_NUM; k++) begin
        if (!kw_hit(k, keyword_position, char_code))
          keyword_match_mask_next[k] = 1'b0;
      end
      if (keyword_position != POS_MAX)
        keyword_position_next = keyword_position + 5'd1;
    end else begin
      if (number_phase == PH_START) begin
        if (blank) begin
          skip = 1'b1;
        end else if (sign) begin
          number_negative_next = (char_code == 8'd45);
          number_phase_next    = PH_DIGITS;
          skip                 = 1'b1;
        end else begin
          number_phase_next = digit ? PH_DIGITS : PH_STOP;
        end
      end
      if (!skip && number_phase_next == PH_DIGITS) begin
        if (digit)
          number_accumulator_next = (prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : prod[30:0];
        else
          number_phase_next = PH_STOP;
      end
    end

    p2_en   = end_of_line && !in_first_token_next && (found_command_next != CMD_NONE);
    sum_cnt = (found_command_next != CMD_NONE) ? separator_count_next : 16'd0;

    grp.mask = {p1_en, p2_en, end_of_line};

    grp.p1.is_summary   = 1'b0;
    grp.p1.param_value  = number_negative ? 31'd0 : number_accumulator;
    grp.p1.param_index  = (separator_count != 16'd0) ? separator_count - 16'd1 : 16'd0;
    grp.p1.cmd_code     = found_command;
    grp.p1.param_count  = 16'd0;
    grp.p1.is_valid     = 1'b0;

    grp.p2.is_summary   = 1'b0;
    grp.p2.param_value  = number_negative_next ? 31'd0 : number_accumulator_next;
    grp.p2.param_index  = (separator_count_next != 16'd0) ?
                          separator_count_next - 16'd1 : 16'd0;
    grp.p2.cmd_code     = found_command_next;
    grp.p2.param_count  = 16'd0;
    grp.p2.is_valid     = 1'b0;

    grp.sm.is_summary   = 1'b1;
    grp.sm.param_value  = 31'd0;
    grp.sm.param_index  = 16'd0;
    grp.sm.cmd_code     = found_command_next;
    grp.sm.param_count  = sum_cnt;
    grp.sm.is_valid     = count_ok(found_command_next, sum_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_line)) begin
      keyword_position   <= '0;
      keyword_match_mask <= '1;
      in_first_token     <= 1'b1;
      found_command      <= CMD_NONE;
      separator_count    <= '0;
      number_accumulator <= '0;
      number_negative    <= 1'b0;
      number_phase       <= PH_START;
    end else if (accept) begin
      keyword_position   <= keyword_position_next;
      keyword_match_mask <= keyword_match_mask_next;
      in_first_token     <= in_first_token_next;
      found_command      <= found_command_next;
      separator_count    <= separator_count_next;
      number_accumulator <= number_accumulator_next;
      number_negative    <= number_negative_next;
      number_phase       <= number_phase_next;
    end
  end

endmodule

// ----- src/clt_out.sv -----
// ----------------------------------------------------------------------------
// clt_out
// Result register: holds the up to three results of one input beat and
// hands them out one beat at a time, flagging the last of the group.
// ----------------------------------------------------------------------------
module clt_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  clt_pkg::grp_t  grp,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output clt_pkg::res_t  res,
  output logic           last
);
  import clt_pkg::*;

  logic [2:0] vld;
  logic [2:0] vld_next;
  res_t       ent_p1, ent_p2, ent_sm;
  logic [2:0] rest;
  logic       take;
  logic       load;

  always_comb begin
    priority if (vld[2]) begin
      res  = ent_p1;
      rest = {1'b0, vld[1:0]};
    end else if (vld[1]) begin
      res  = ent_p2;
      rest = {2'b00, vld[0]};
    end else begin
      res  = ent_sm;
      rest = 3'b000;
    end
    out_valid = |vld;
    last      = (rest == 3'b000);
    take      = out_valid && !out_stall;
    busy      = out_valid && !(take && last);
    load      = accept && (grp.mask != 3'b000);
    vld_next  = load ? grp.mask : (take ? rest : vld);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_p1 <= grp.p1;
      ent_p2 <= grp.p2;
      ent_sm <= grp.sm;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("results pending after reset");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !busy)
    else $error("new group loaded over undelivered results");
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res))
    else $error("stalled result lost or changed");
  a_group_rest: assert property (@(posedge clk) disable iff (rst)
    take && !last |=> out_valid)
    else $error("remaining results of a group dropped");

endmodule
